FILE: design/tts_pkg.sv
// Shared codes for the task table scheduler: operation codes, selection
// policies and entry status values. No dependencies.
`default_nettype none

package tts_pkg;

  // Operation codes carried on the input tuser
  localparam logic [2:0] FN_APPEND = 3'd0;
  localparam logic [2:0] FN_WAKE   = 3'd1;
  localparam logic [2:0] FN_SETST  = 3'd2;
  localparam logic [2:0] FN_SELECT = 3'd3;
  localparam logic [2:0] FN_REMOVE = 3'd4;
  localparam logic [2:0] FN_CLKRST = 3'd5;

  // Selection policies
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;
  localparam logic [1:0] POL_PRIO = 2'd3;

  // Entry status
  localparam logic [1:0] ST_READY    = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_BLOCKED  = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // Width of one stored entry payload: id, priority, burst
  localparam int unsigned ENTRY_W = 40;

endpackage

`default_nettype wire

FILE: design/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the task table stores; no package dependency.
`default_nettype none

module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/task_table_scheduler_core.sv
// Task table scheduler top level: sequencer, scan/compare unit and table RAMs.
// Depends on tts_pkg and tts_ram.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tuser func, in_tdata op fields
//  out_    | out | out_tvalid / out_tready| out_tuser ok, out_tdata result
//  cfg_    | in  | cfg_wen                | cfg_wdata policy
//
// Operations: append, set state, clock reset and unknown codes run without a
// table scan; wake, select and remove scan the table, one table entry per cycle
// through the single read port of the table RAMs.
// Reset: control state clears synchronously; table entries are undefined until
// appended, so there is no clearing pass.
// Stalls: a waiting result sits in the output register while the next item is
// accepted; a second result waits until the first is taken.
`default_nettype none

module task_table_scheduler_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_wdata,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,  // [2:0] func
  input  wire logic [47:0] in_tdata,  // [3:0] slot, [19:4] task_id,
                                      // [27:20] priority_req, [43:28] burst,
                                      // [45:44] new_state, [47:46] zero
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tuser, // [0] ok
  output logic [63:0]      out_tdata  // [3:0] chosen_slot, [19:4] chosen_id,
                                      // [51:20] dispatch_tick,
                                      // [56:52] entries_used, [63:57] zero
);

  localparam int unsigned IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > 4) ? CW : 4;
  localparam int unsigned WW   = CMPW + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [31:0]   tick_r, tick_nxt;
  logic [1:0]    policy_r, policy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          vld_r, vld_nxt;
  logic [CW-1:0] remaining_r, remaining_nxt;
  logic          found_r, found_nxt;

  // payload state
  logic [2:0]    op_func_r;
  logic [3:0]    op_slot_r;
  logic [15:0]   op_id_r;
  logic [7:0]    op_prio_r;
  logic [15:0]   op_burst_r;
  logic [1:0]    op_nst_r;
  logic [IW-1:0] addr_r, addr_nxt;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]   best_key_r, best_key_nxt;
  logic [15:0]   best_id_r, best_id_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic [3:0]    res_slot_r, res_slot_nxt;
  logic [15:0]   res_id_r, res_id_nxt;
  logic [31:0]   res_tick_r, res_tick_nxt;
  logic          out_ok_r;
  logic [3:0]    out_slot_r;
  logic [15:0]   out_id_r;
  logic [31:0]   out_tick_r;
  logic [4:0]    out_used_r;

  // table RAM ports
  logic                     main_we, stat_we, rd_en;
  logic [IW-1:0]            main_waddr, stat_waddr;
  logic [tts_pkg::ENTRY_W-1:0] main_wdata, main_rdata;
  logic [1:0]               stat_wdata, stat_rdata;

  // widened views for compares
  logic [WW-1:0] used_w, slot_w, addr_inc_w, best_idx_w, used_m1_w, ptr_w;
  logic [WW-1:0] ptr_adj_w;
  logic [CW-1:0] used_m1;
  logic [IW-1:0] ptr_adj;
  logic [15:0]   rd_id, rd_key, best_next_w_id;
  logic [7:0]    rd_prio;
  logic [15:0]   rd_burst;
  logic          rd_ready, slot_in_use, better;

  assign used_w      = WW'(used_r);
  assign slot_w      = WW'(op_slot_r);
  assign addr_inc_w  = WW'(addr_r) + WW'(1);
  assign best_idx_w  = WW'(best_idx_r);
  assign used_m1     = used_r - CW'(1);
  assign used_m1_w   = WW'(used_m1);
  assign ptr_w       = WW'(ptr_r);
  assign slot_in_use = (slot_w < used_w);
  assign ptr_adj     = (ptr_w > slot_w) ? (ptr_r - IW'(1)) : ptr_r;
  assign ptr_adj_w   = WW'(ptr_adj);

  assign rd_id    = main_rdata[39:24];
  assign rd_prio  = main_rdata[23:16];
  assign rd_burst = main_rdata[15:0];
  assign rd_ready = (stat_rdata == tts_pkg::ST_READY);
  assign rd_key   = (policy_r == tts_pkg::POL_SJF) ? rd_burst : {8'd0, rd_prio};
  assign better   = !found_r || (rd_key < best_key_r) ||
                    ((rd_key == best_key_r) && (rd_id < best_id_r));
  assign best_next_w_id = best_id_r;

  assign rd_en   = (state_r == S_SCAN) && (remaining_r != '0);
  assign vld_nxt = rd_en;

  tts_ram #(.WIDTH(tts_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (main_rdata)
  );

  tts_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (stat_waddr),
    .wdata (stat_wdata),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (stat_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {7'd0, out_used_r, out_tick_r, out_id_r, out_slot_r};

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    tick_nxt      = tick_r;
    policy_nxt    = policy_r;
    out_valid_nxt = out_valid_r;
    remaining_nxt = remaining_r;
    found_nxt     = found_r;
    addr_nxt      = addr_r;
    best_idx_nxt  = best_idx_r;
    best_key_nxt  = best_key_r;
    best_id_nxt   = best_next_w_id;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    res_id_nxt    = res_id_r;
    res_tick_nxt  = res_tick_r;
    main_we       = 1'b0;
    main_waddr    = used_r[IW-1:0];
    main_wdata    = {op_id_r, op_prio_r, op_burst_r};
    stat_we       = 1'b0;
    stat_waddr    = used_r[IW-1:0];
    stat_wdata    = tts_pkg::ST_READY;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_ok_nxt    = 1'b0;
        res_slot_nxt  = '0;
        res_id_nxt    = '0;
        res_tick_nxt  = '0;
        found_nxt     = 1'b0;
        addr_nxt      = '0;
        remaining_nxt = used_r;
        state_nxt     = S_FINISH;
        case (op_func_r)
          tts_pkg::FN_APPEND: begin
            if (used_r < CW'(TABLE_DEPTH)) begin
              main_we    = 1'b1;
              stat_we    = 1'b1;
              used_nxt   = used_r + CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          tts_pkg::FN_WAKE: begin
            state_nxt = S_SCAN;
          end
          tts_pkg::FN_SETST: begin
            if (slot_in_use) begin
              stat_we    = 1'b1;
              stat_waddr = slot_w[IW-1:0];
              stat_wdata = op_nst_r;
              res_ok_nxt = 1'b1;
            end
          end
          tts_pkg::FN_SELECT: begin
            if (policy_r == tts_pkg::POL_RR) begin
              addr_nxt = ptr_r;
            end
            state_nxt = S_SCAN;
          end
          tts_pkg::FN_REMOVE: begin
            if (slot_in_use) begin
              // copy entries above the slot down by one
              addr_nxt      = IW'(slot_w + WW'(1));
              remaining_nxt = CW'(used_w - slot_w - WW'(1));
              state_nxt     = S_SCAN;
            end
          end
          tts_pkg::FN_CLKRST: begin
            tick_nxt   = '0;
            res_ok_nxt = 1'b1;
          end
          default: begin
            res_ok_nxt = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        if (rd_en) begin
          remaining_nxt = remaining_r - CW'(1);
          addr_nxt      = (addr_inc_w == used_w) ? '0 : addr_inc_w[IW-1:0];
        end
        if (!rd_en && !vld_r) begin
          state_nxt = S_COMMIT;
        end
        if (vld_r) begin
          case (op_func_r)
            tts_pkg::FN_WAKE: begin
              if (rd_id == op_id_r) begin
                found_nxt    = 1'b1;
                best_idx_nxt = idx_r;
                state_nxt    = S_COMMIT;
              end
            end
            tts_pkg::FN_SELECT: begin
              if (policy_r == tts_pkg::POL_FIFO || policy_r == tts_pkg::POL_RR) begin
                if (rd_ready) begin
                  found_nxt    = 1'b1;
                  best_idx_nxt = idx_r;
                  best_id_nxt  = rd_id;
                  state_nxt    = S_COMMIT;
                end
              end else if (rd_ready && better) begin
                found_nxt    = 1'b1;
                best_idx_nxt = idx_r;
                best_id_nxt  = rd_id;
                best_key_nxt = rd_key;
              end
            end
            default: begin
              // remove: move the entry just read one place down
              main_we    = 1'b1;
              main_waddr = idx_r - IW'(1);
              main_wdata = main_rdata;
              stat_we    = 1'b1;
              stat_waddr = idx_r - IW'(1);
              stat_wdata = stat_rdata;
            end
          endcase
        end
      end
      S_COMMIT: begin
        state_nxt = S_FINISH;
        case (op_func_r)
          tts_pkg::FN_WAKE: begin
            if (found_r) begin
              stat_we      = 1'b1;
              stat_waddr   = best_idx_r;
              stat_wdata   = tts_pkg::ST_READY;
              res_ok_nxt   = 1'b1;
              res_slot_nxt = best_idx_w[3:0];
            end
          end
          tts_pkg::FN_SELECT: begin
            if (found_r) begin
              stat_we      = 1'b1;
              stat_waddr   = best_idx_r;
              stat_wdata   = tts_pkg::ST_RUNNING;
              res_ok_nxt   = 1'b1;
              res_slot_nxt = best_idx_w[3:0];
              res_id_nxt   = best_id_r;
              res_tick_nxt = tick_r;
              tick_nxt     = tick_r + 32'd1;
              if (policy_r == tts_pkg::POL_RR) begin
                ptr_nxt = ((best_idx_w + WW'(1)) == used_w) ? '0 : (best_idx_r + IW'(1));
              end
            end
          end
          default: begin
            // remove: shrink the table and keep the pointer in range
            used_nxt   = used_m1;
            res_ok_nxt = 1'b1;
            if (used_m1 == '0 || ptr_adj_w >= used_m1_w) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = ptr_adj;
            end
          end
        endcase
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wen) begin
      policy_nxt = cfg_wdata;
      ptr_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      ptr_r       <= '0;
      tick_r      <= '0;
      policy_r    <= tts_pkg::POL_FIFO;
      out_valid_r <= 1'b0;
      vld_r       <= 1'b0;
      remaining_r <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ptr_r       <= ptr_nxt;
      tick_r      <= tick_nxt;
      policy_r    <= policy_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      remaining_r <= remaining_nxt;
      found_r     <= found_nxt;
    end
  end

  logic [WW-1:0] used_out_w;
  assign used_out_w = WW'(used_r);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_func_r  <= in_tuser;
      op_slot_r  <= in_tdata[3:0];
      op_id_r    <= in_tdata[19:4];
      op_prio_r  <= in_tdata[27:20];
      op_burst_r <= in_tdata[43:28];
      op_nst_r   <= in_tdata[45:44];
    end
    addr_r     <= addr_nxt;
    idx_r      <= addr_r;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_id_r  <= best_id_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_id_r   <= res_id_nxt;
    res_tick_r <= res_tick_nxt;
    if (state_r == S_FINISH && (!out_valid_r || out_tready)) begin
      out_ok_r   <= res_ok_r;
      out_slot_r <= res_slot_r;
      out_id_r   <= res_id_r;
      out_tick_r <= res_tick_r;
      out_used_r <= used_out_w[4:0];
    end
  end

  // table never overfills
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_w <= WW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // round-robin pointer stays inside the table
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r == '0) || (ptr_w < used_w))
    else $error("round-robin pointer out of range");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a second item while busy");

  // a dispatch advances the clock by exactly one
  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && op_func_r == tts_pkg::FN_SELECT && found_r && !cfg_wen)
    |=> (tick_r == $past(tick_r) + 32'd1))
    else $error("dispatch clock did not advance");

endmodule

`default_nettype wire

FILE: verif/task_table_scheduler_core_tb.sv
// Testbench for task_table_scheduler_core: a directed table, then random
// operations under every selection policy, checked against a predictor.
// Depends on tts_pkg and the task_table_scheduler_core RTL.
`timescale 1ns / 1ps

module task_table_scheduler_core_tb;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned ITEMS_PHASE  = 225;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_AT      = 400;  // results seen before the long stall
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam logic [2:0] FN_UNUSED6    = 3'd6;
  localparam logic [2:0] FN_UNUSED7    = 3'd7;

  localparam logic [2:0] FN_APPEND   = tts_pkg::FN_APPEND;
  localparam logic [2:0] FN_WAKE     = tts_pkg::FN_WAKE;
  localparam logic [2:0] FN_SETST    = tts_pkg::FN_SETST;
  localparam logic [2:0] FN_SELECT   = tts_pkg::FN_SELECT;
  localparam logic [2:0] FN_REMOVE   = tts_pkg::FN_REMOVE;
  localparam logic [2:0] FN_CLKRST   = tts_pkg::FN_CLKRST;
  localparam logic [1:0] POL_FIFO    = tts_pkg::POL_FIFO;
  localparam logic [1:0] POL_SJF     = tts_pkg::POL_SJF;
  localparam logic [1:0] POL_RR      = tts_pkg::POL_RR;
  localparam logic [1:0] POL_PRIO    = tts_pkg::POL_PRIO;
  localparam logic [1:0] ST_READY    = tts_pkg::ST_READY;
  localparam logic [1:0] ST_RUNNING  = tts_pkg::ST_RUNNING;
  localparam logic [1:0] ST_BLOCKED  = tts_pkg::ST_BLOCKED;
  localparam logic [1:0] ST_FINISHED = tts_pkg::ST_FINISHED;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [15:0] tid;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [1:0]  nst;
  } sched_op_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [15:0] id;
    logic [31:0] tick;
    logic [4:0]  used;
  } sched_res_t;

  typedef struct packed {
    sched_op_t  op;
    logic       typed;
    sched_res_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wen;
  logic [1:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        out_tuser;
  logic [63:0] out_tdata;

  // predictor copy of the task table
  logic [15:0] tbl_id    [DEPTH];
  logic [7:0]  tbl_prio  [DEPTH];
  logic [15:0] tbl_burst [DEPTH];
  logic [1:0]  tbl_st    [DEPTH];
  logic [4:0]  tbl_used;
  logic [3:0]  rr_ptr;
  logic [31:0] tick_now;
  logic [1:0]  cur_policy;

  sched_res_t result_q [$];
  dir_row_t   dir_tab [$];
  int unsigned mismatches, items_sent, results_seen, cycles;
  int unsigned n_dispatch, n_full_reject, n_rr_dispatch;
  bit send_quiet, recv_quiet;

  task_table_scheduler_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, result_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic sched_op_t mk_op(logic [2:0] f, logic [3:0] s, logic [15:0] id,
                                      logic [7:0] p, logic [15:0] b, logic [1:0] n);
    return {f, s, id, p, b, n};
  endfunction

  function automatic sched_res_t mk_res(logic ok, logic [3:0] s, logic [15:0] id,
                                        logic [31:0] t, logic [4:0] u);
    return {ok, s, id, t, u};
  endfunction

  // Apply one operation to the predictor table and return the result it causes.
  function automatic sched_res_t sched_apply(sched_op_t op);
    sched_res_t r;
    int pick;
    int idx;
    r = '0;
    pick = -1;
    case (op.func)
      FN_APPEND: begin
        if (tbl_used < DEPTH) begin
          tbl_id[tbl_used]    = op.tid;
          tbl_prio[tbl_used]  = op.prio;
          tbl_burst[tbl_used] = op.burst;
          tbl_st[tbl_used]    = ST_READY;
          tbl_used = tbl_used + 5'd1;
          r.ok = 1'b1;
        end
      end
      FN_WAKE: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_id[i] == op.tid) begin
            tbl_st[i] = ST_READY;
            r.ok = 1'b1;
            r.slot = 4'(i);
            break;
          end
        end
      end
      FN_SETST: begin
        if (op.slot < tbl_used) begin
          tbl_st[op.slot] = op.nst;
          r.ok = 1'b1;
        end
      end
      FN_SELECT: begin
        if (cur_policy == POL_RR) begin
          for (int k = 0; k < tbl_used; k++) begin
            idx = (rr_ptr + k) % tbl_used;
            if (tbl_st[idx] == ST_READY) begin
              pick = idx;
              rr_ptr = 4'((idx + 1) % tbl_used);
              break;
            end
          end
        end else begin
          // fifo keeps the first ready entry; sjf and priority replace on a
          // smaller key, ties going to the lower id
          for (int i = 0; i < tbl_used; i++) begin
            if (tbl_st[i] != ST_READY) continue;
            if (pick < 0) pick = i;
            else if (cur_policy == POL_SJF && (tbl_burst[i] < tbl_burst[pick] ||
                     (tbl_burst[i] == tbl_burst[pick] && tbl_id[i] < tbl_id[pick])))
              pick = i;
            else if (cur_policy == POL_PRIO && (tbl_prio[i] < tbl_prio[pick] ||
                     (tbl_prio[i] == tbl_prio[pick] && tbl_id[i] < tbl_id[pick])))
              pick = i;
          end
        end
        if (pick >= 0) begin
          tbl_st[pick] = ST_RUNNING;
          r.ok = 1'b1;
          r.slot = 4'(pick);
          r.id = tbl_id[pick];
          r.tick = tick_now;
          tick_now = tick_now + 32'd1;
        end
      end
      FN_REMOVE: begin
        if (op.slot < tbl_used) begin
          for (int i = op.slot; i + 1 < tbl_used; i++) begin
            tbl_id[i]    = tbl_id[i+1];
            tbl_prio[i]  = tbl_prio[i+1];
            tbl_burst[i] = tbl_burst[i+1];
            tbl_st[i]    = tbl_st[i+1];
          end
          tbl_used = tbl_used - 5'd1;
          if (tbl_used == 0) begin
            rr_ptr = '0;
          end else begin
            if (rr_ptr > op.slot) rr_ptr = rr_ptr - 4'd1;
            if (rr_ptr >= tbl_used) rr_ptr = '0;
          end
          r.ok = 1'b1;
        end
      end
      FN_CLKRST: begin
        tick_now = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.used = tbl_used;
    return r;
  endfunction

  function automatic logic [15:0] draw_wide16();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
  endfunction

  // Mostly well-formed operations on live entries; a share of noise on top.
  // Growing stretches favor appends so the table fills up, the others drain it.
  function automatic sched_op_t draw_op(bit growing);
    sched_op_t op;
    int r;
    op.slot  = 4'($urandom_range(0, 15));
    op.tid   = draw_wide16();
    op.prio  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    op.burst = draw_wide16();
    op.nst   = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < (growing ? 40 : 12))      op.func = FN_APPEND;
    else if (r < (growing ? 65 : 37)) op.func = FN_SELECT;
    else if (r < (growing ? 75 : 49)) op.func = FN_WAKE;
    else if (r < (growing ? 85 : 60)) op.func = FN_SETST;
    else if (r < 95)                  op.func = FN_REMOVE;
    else if (r < 98)                  op.func = FN_CLKRST;
    else op.func = ($urandom_range(0, 1) != 0) ? FN_UNUSED6 : FN_UNUSED7;
    if (tbl_used > 0 && $urandom_range(0, 9) != 0) begin
      if (op.func == FN_WAKE) op.tid = tbl_id[$urandom_range(0, tbl_used - 1)];
      if (op.func == FN_SETST || op.func == FN_REMOVE)
        op.slot = 4'($urandom_range(0, tbl_used - 1));
    end
    return op;
  endfunction

  task automatic offer(input sched_op_t op, input logic typed, input sched_res_t want);
    int gap;
    sched_res_t pred;
    if ($urandom_range(0, 99) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op.func;
    in_tdata  <= {2'b00, op.nst, op.burst, op.prio, op.tid, op.slot};
    do @(posedge clk); while (!in_tready);
    pred = sched_apply(op);
    result_q.push_back(typed ? want : pred);
    items_sent++;
    if (op.func == FN_SELECT && pred.ok) n_dispatch++;
    if (op.func == FN_SELECT && pred.ok && cur_policy == POL_RR) n_rr_dispatch++;
    if (op.func == FN_APPEND && !pred.ok) n_full_reject++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] p);
    cfg_wen   <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_policy = p;
    rr_ptr = '0;
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("error at cycle %0d: %s", cycles, msg);
  endtask

  // result checker
  always @(posedge clk) begin : result_chk
    sched_res_t got, want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = {out_tuser, out_tdata[3:0], out_tdata[19:4], out_tdata[51:20], out_tdata[56:52]};
      results_seen++;
      if (result_q.size() == 0) begin
        flag_error($sformatf("unexpected item ok %0d slot %0d id %h tick %0d used %0d",
                             got.ok, got.slot, got.id, got.tick, got.used));
      end else begin
        want = result_q.pop_front();
        if (got.ok !== want.ok || got.slot !== want.slot || got.id !== want.id ||
            got.tick !== want.tick || got.used !== want.used)
          flag_error($sformatf({"result %0d: ok %0d/%0d slot %0d/%0d id %h/%h ",
                                "tick %0d/%0d used %0d/%0d (expected/actual)"},
                               results_seen, want.ok, got.ok, want.slot, got.slot,
                               want.id, got.id, want.tick, got.tick, want.used, got.used));
      end
    end
  end

  // result receiver: random stalls, one long hold-off to back the block up
  initial begin : receiver
    int wait_n;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 79) == 0) recv_quiet = !recv_quiet;
      wait_n = recv_quiet ? 0 : $urandom_range(0, 6);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        wait_n = HOLD_CYCLES;
      end
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin : stimulus
    bit growing;
    logic [1:0] phase_pol [NUM_PHASES];
    phase_pol = '{POL_RR, POL_FIFO, POL_SJF, POL_PRIO, POL_RR, POL_SJF, POL_PRIO, POL_FIFO};
    items_sent = 0;
    n_dispatch = 0;
    n_rr_dispatch = 0;
    n_full_reject = 0;
    send_quiet = 1'b0;
    tbl_used = '0;
    rr_ptr = '0;
    tick_now = '0;
    cur_policy = POL_FIFO;
    rst_n     <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;

    // empty table, unused codes, then a three-entry table under fifo
    dir_tab.push_back({mk_op(FN_SELECT, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_WAKE, 0, 16'hFFFF, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_SETST, 15, 0, 0, 0, ST_FINISHED), 1'b1, mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_REMOVE, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_UNUSED6, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_UNUSED7, 15, 16'hFFFF, 8'hFF, 16'hFFFF, ST_FINISHED), 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_CLKRST, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_APPEND, 15, 16'hFFFF, 8'hFF, 16'hFFFF, ST_FINISHED), 1'b1,
                       mk_res(1, 0, 0, 0, 1)});
    dir_tab.push_back({mk_op(FN_APPEND, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 0, 0, 0, 2)});
    dir_tab.push_back({mk_op(FN_APPEND, 0, 5, 0, 0, ST_READY), 1'b1, mk_res(1, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_SELECT, 0, 0, 0, 0, ST_READY), 1'b1,
                       mk_res(1, 0, 16'hFFFF, 0, 3)});
    dir_tab.push_back({mk_op(FN_SELECT, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 1, 0, 1, 3)});
    dir_tab.push_back({mk_op(FN_SELECT, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 2, 5, 2, 3)});
    dir_tab.push_back({mk_op(FN_SELECT, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_WAKE, 0, 5, 0, 0, ST_READY), 1'b1, mk_res(1, 2, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_WAKE, 0, 16'h1234, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_SETST, 1, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_SETST, 0, 0, 0, 0, ST_BLOCKED), 1'b1, mk_res(1, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_SETST, 2, 0, 0, 0, ST_FINISHED), 1'b1, mk_res(1, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_SETST, 3, 0, 0, 0, ST_RUNNING), 1'b1, mk_res(0, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_SELECT, 0, 0, 0, 0, ST_READY), 1'b0, mk_res(0, 0, 0, 0, 0)});
    dir_tab.push_back({mk_op(FN_CLKRST, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_REMOVE, 3, 0, 0, 0, ST_READY), 1'b1, mk_res(0, 0, 0, 0, 3)});
    dir_tab.push_back({mk_op(FN_REMOVE, 0, 0, 0, 0, ST_READY), 1'b1, mk_res(1, 0, 0, 0, 2)});
    dir_tab.push_back({mk_op(FN_REMOVE, 1, 0, 0, 0, ST_READY), 1'b0, mk_res(0, 0, 0, 0, 0)});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) offer(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_policy(phase_pol[ph]);
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        growing = ((n / 40) % 2) == 0;
        offer(draw_op(growing), 1'b0, '0);
      end
    end

    drain();
    // catch any stray result after the last expected one
    repeat (40) @(posedge clk);
    $display("sent %0d items and checked %0d results over all four policies",
             items_sent, results_seen);
    $display("%0d dispatches (%0d round robin), %0d appends refused on a full table",
             n_dispatch, n_rr_dispatch, n_full_reject);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: task_table_scheduler_core.f
design/tts_pkg.sv
design/tts_ram.sv
design/task_table_scheduler_core.sv
verif/task_table_scheduler_core_tb.sv
